>>> rtl/pdie_pkg.sv
// Shared constants and types for the prefixed decimal integer extractor.
`timescale 1ns / 1ps
`default_nettype none

package pdie_pkg;

  localparam int PREFIX_MAX = 8;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(PREFIX_MAX + 1);
  localparam int CFG_DATA_W = 8 * PREFIX_MAX;
  localparam int OUT_RAW_W  = 2 + VALUE_BITS + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;
  localparam int PROD_W     = VALUE_BITS + 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [0:0] REG_PREFIX_BYTES  = 1'b0;
  localparam logic [0:0] REG_PREFIX_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_SKIPWS = 3'd1,
    PH_SIGNED = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOPREFIX = 2'd1,
    ST_NODIGIT  = 2'd2,
    ST_SIGNONLY = 2'd3
  } status_t;

  typedef struct packed {
    logic                  value_saturated;
    logic [VALUE_BITS-1:0] parsed_value;
    status_t               parse_status;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/prefixed_decimal_int_extractor_unit.sv
// Top level of the prefixed decimal integer extractor: prefix search, number parse, result stage.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Response bytes enter on the s_axis channel, one byte per transfer; s_axis_tlast marks
//   the last byte of a response. Each byte is consumed in the cycle of its transfer.
//   The prefix is set through the cfg port (index 0: prefix characters, first character
//   in the lowest byte; index 1: prefix length, 9..15 act as 8) while no response is in flight.
//   For every response one result leaves on m_axis: status, signed value and a
//   saturation flag, packed into m_axis_tdata. Bytes other than the last give no result.
//   The result is registered at the transfer of the last byte, into the skid register if
//   the output register keeps an untaken result. Throughput: one byte per cycle while
//   s_axis_tready is high; window compare and magnitude times-ten update are combinational.
//   A two-entry result stage (output register plus skid register) keeps s_axis_tready
//   registered; input stalls only when both entries hold untaken results.
//   Reset (rst, synchronous) clears the parse state, empties the result stage and sets
//   both prefix registers to zero. Parse state also clears after every last byte.
module prefixed_decimal_int_extractor_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [pdie_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  wire logic                              s_axis_tlast,  // end_of_response
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] parse_status, [33:2] parsed_value, [34] value_saturated, rest zero
  output logic [pdie_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  localparam int PM = pdie_pkg::PREFIX_MAX;
  localparam int VB = pdie_pkg::VALUE_BITS;
  localparam int CW = pdie_pkg::CNT_W;
  localparam int PW = pdie_pkg::PROD_W;

  logic [pdie_pkg::CFG_DATA_W-1:0] prefix_bytes;
  logic [3:0]                      prefix_length;

  logic [PM-1:0][7:0]     window;
  logic [PM-1:0][7:0]     window_next;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  pdie_pkg::phase_t       phase;
  pdie_pkg::phase_t       phase_next;
  logic                   negative;
  logic                   negative_next;
  logic [VB-1:0]          magnitude;
  logic [VB-1:0]          magnitude_next;
  logic                   overflow;
  logic                   overflow_next;
  pdie_pkg::status_t      final_status;
  pdie_pkg::status_t      final_status_next;

  pdie_pkg::result_t      result_next;
  pdie_pkg::result_t      out_reg;
  pdie_pkg::result_t      skid_reg;
  logic                   out_valid;
  logic                   skid_valid;

  logic                   in_fire;
  logic                   out_fire;
  logic                   push;

  logic [CW-1:0]          len_eff;
  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [PW-1:0]          prod;
  logic [VB-1:0]          mag_limit;
  logic                   match;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign push     = in_fire && s_axis_tlast;

  assign len_eff   = (prefix_length > 4'(PM)) ? CW'(PM) : CW'(prefix_length);
  assign is_digit  = (s_axis_tdata >= pdie_pkg::CH_ZERO) && (s_axis_tdata <= pdie_pkg::CH_NINE);
  assign digit_val = 4'(s_axis_tdata - pdie_pkg::CH_ZERO);
  assign prod      = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1) + PW'(digit_val);
  assign mag_limit = negative ? (VB'(1) << (VB - 1)) : ((VB'(1) << (VB - 1)) - VB'(1));

  // Window shift and prefix compare for every possible length.
  always_comb begin
    logic hit;
    window_next = window;
    count_next  = count;
    match       = 1'b0;
    if ((phase == pdie_pkg::PH_SEARCH) && (len_eff != '0)) begin
      for (int i = PM - 1; i > 0; i--) begin
        window_next[i] = window[i-1];
      end
      window_next[0] = s_axis_tdata;
      if (count < CW'(PM)) begin
        count_next = count + CW'(1);
      end
    end
    for (int l = 1; l <= PM; l++) begin
      hit = (len_eff == CW'(l)) && (count_next >= CW'(l));
      for (int i = 0; i < l; i++) begin
        if (window_next[l-1-i] != prefix_bytes[8*i +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        match = 1'b1;
      end
    end
  end

  // Next parse state.
  always_comb begin
    pdie_pkg::phase_t ph;
    logic             take_digit;
    phase_next        = phase;
    negative_next     = negative;
    magnitude_next    = magnitude;
    overflow_next     = overflow;
    final_status_next = final_status;
    take_digit        = 1'b0;
    ph                = phase;
    if (phase == pdie_pkg::PH_SEARCH) begin
      if (len_eff == '0) begin
        ph = pdie_pkg::PH_SKIPWS;
      end else if (match) begin
        phase_next = pdie_pkg::PH_SKIPWS;
      end
    end
    unique case (ph)
      pdie_pkg::PH_SKIPWS: begin
        phase_next = pdie_pkg::PH_SKIPWS;
        priority if ((s_axis_tdata == pdie_pkg::CH_SPACE) || (s_axis_tdata == pdie_pkg::CH_TAB)) begin
          phase_next = pdie_pkg::PH_SKIPWS;
        end else if (s_axis_tdata == pdie_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = pdie_pkg::PH_SIGNED;
        end else if (s_axis_tdata == pdie_pkg::CH_PLUS) begin
          phase_next = pdie_pkg::PH_SIGNED;
        end else if (is_digit) begin
          take_digit = 1'b1;
          phase_next = pdie_pkg::PH_DIGITS;
        end else begin
          final_status_next = pdie_pkg::ST_NODIGIT;
          phase_next        = pdie_pkg::PH_DONE;
        end
      end
      pdie_pkg::PH_SIGNED: begin
        if (is_digit) begin
          take_digit = 1'b1;
          phase_next = pdie_pkg::PH_DIGITS;
        end else begin
          final_status_next = pdie_pkg::ST_SIGNONLY;
          phase_next        = pdie_pkg::PH_DONE;
        end
      end
      pdie_pkg::PH_DIGITS: begin
        if (is_digit) begin
          take_digit = 1'b1;
        end else begin
          final_status_next = pdie_pkg::ST_OK;
          phase_next        = pdie_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
    if (take_digit && !overflow) begin
      if (prod > PW'(mag_limit)) begin
        overflow_next  = 1'b1;
        magnitude_next = mag_limit;
      end else begin
        magnitude_next = prod[VB-1:0];
      end
    end
  end

  // Result fields from the state after the last byte.
  always_comb begin
    pdie_pkg::status_t st;
    unique case (phase_next)
      pdie_pkg::PH_SEARCH: st = pdie_pkg::ST_NOPREFIX;
      pdie_pkg::PH_SKIPWS: st = pdie_pkg::ST_NODIGIT;
      pdie_pkg::PH_SIGNED: st = pdie_pkg::ST_SIGNONLY;
      pdie_pkg::PH_DIGITS: st = pdie_pkg::ST_OK;
      default:             st = final_status_next;
    endcase
    result_next.parse_status    = st;
    result_next.parsed_value    = '0;
    result_next.value_saturated = 1'b0;
    if (st == pdie_pkg::ST_OK) begin
      result_next.parsed_value    = negative_next ? (VB'(0) - magnitude_next) : magnitude_next;
      result_next.value_saturated = overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes  <= '0;
      prefix_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdie_pkg::REG_PREFIX_BYTES:  prefix_bytes  <= cfg_data;
        pdie_pkg::REG_PREFIX_LENGTH: prefix_length <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      window       <= '0;
      count        <= '0;
      phase        <= pdie_pkg::PH_SEARCH;
      negative     <= 1'b0;
      magnitude    <= '0;
      overflow     <= 1'b0;
      final_status <= pdie_pkg::ST_NOPREFIX;
    end else if (in_fire) begin
      window       <= window_next;
      count        <= count_next;
      phase        <= phase_next;
      negative     <= negative_next;
      magnitude    <= magnitude_next;
      overflow     <= overflow_next;
      final_status <= final_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_reg <= result_next;
      end else begin
        skid_reg <= result_next;
      end
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{pdie_pkg::OUT_PAD_W{1'b0}}, out_reg};

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for prefixed_decimal_int_extractor_unit: random stream traffic checked by a parse model.
`timescale 1ns / 1ps

module tb;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_CHARS    = 62;

  typedef struct packed {
    logic [7:0] chr;
    logic       eor;
  } resp_char_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [0:0]                      cfg_index = '0;
  logic [pdie_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b1;
  logic [pdie_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  prefixed_decimal_int_extractor_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state and its copy of the prefix registers
  logic [63:0]       pfx_chars = '0;
  logic [3:0]        pfx_len = '0;
  logic [7:0]        win [pdie_pkg::PREFIX_MAX];
  int unsigned       win_fill;
  pdie_pkg::phase_t  phase;
  logic              neg;
  logic              ovf;
  logic [31:0]       mag;
  pdie_pkg::status_t fstat;

  resp_char_t        pending_chars [$];
  pdie_pkg::result_t expected_parses [$];
  resp_char_t        draft [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  phase_chars = 0;
  bit  calm = 1'b0;
  bit  in_taken = 1'b0;
  int  src_gap = 0;
  int  dst_gap = 0;

  task automatic clear_parse();
    for (int i = 0; i < pdie_pkg::PREFIX_MAX; i++) win[i] = 8'h00;
    win_fill = 0;
    phase = pdie_pkg::PH_SEARCH;
    neg = 1'b0;
    mag = '0;
    ovf = 1'b0;
    fstat = pdie_pkg::ST_NOPREFIX;
  endtask

  task automatic add_digit(input logic [3:0] d);
    logic [63:0] nxt;
    logic [31:0] lim;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    nxt = {32'b0, mag} * 64'd10 + {60'b0, d};
    if (!ovf) begin
      if (nxt > {32'b0, lim}) begin
        ovf = 1'b1;
        mag = lim;
      end else begin
        mag = nxt[31:0];
      end
    end
  endtask

  task automatic absorb_char(input logic [7:0] b, input logic eor);
    int unsigned       elen;
    bit                is_digit;
    bit                hit;
    bit                parse_on;
    pdie_pkg::status_t st;
    pdie_pkg::result_t r;
    is_digit = (b >= pdie_pkg::CH_ZERO) && (b <= pdie_pkg::CH_NINE);
    elen = (pfx_len > pdie_pkg::PREFIX_MAX) ? pdie_pkg::PREFIX_MAX : pfx_len;
    parse_on = 1'b1;
    if (phase == pdie_pkg::PH_SEARCH) begin
      if (elen == 0) begin
        phase = pdie_pkg::PH_SKIPWS;
      end else begin
        for (int i = pdie_pkg::PREFIX_MAX - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (win_fill < pdie_pkg::PREFIX_MAX) win_fill++;
        hit = (win_fill >= elen);
        for (int i = 0; i < elen; i++)
          if (win[elen-1-i] != pfx_chars[8*i +: 8]) hit = 1'b0;
        if (hit) phase = pdie_pkg::PH_SKIPWS;
        parse_on = 1'b0;
      end
    end
    if (parse_on) begin
      case (phase)
        pdie_pkg::PH_SKIPWS: begin
          if (b == pdie_pkg::CH_MINUS) begin
            neg = 1'b1;
            phase = pdie_pkg::PH_SIGNED;
          end else if (b == pdie_pkg::CH_PLUS) begin
            phase = pdie_pkg::PH_SIGNED;
          end else if (is_digit) begin
            add_digit(4'(b - pdie_pkg::CH_ZERO));
            phase = pdie_pkg::PH_DIGITS;
          end else if (b != pdie_pkg::CH_SPACE && b != pdie_pkg::CH_TAB) begin
            fstat = pdie_pkg::ST_NODIGIT;
            phase = pdie_pkg::PH_DONE;
          end
        end
        pdie_pkg::PH_SIGNED: begin
          if (is_digit) begin
            add_digit(4'(b - pdie_pkg::CH_ZERO));
            phase = pdie_pkg::PH_DIGITS;
          end else begin
            fstat = pdie_pkg::ST_SIGNONLY;
            phase = pdie_pkg::PH_DONE;
          end
        end
        pdie_pkg::PH_DIGITS: begin
          if (is_digit) begin
            add_digit(4'(b - pdie_pkg::CH_ZERO));
          end else begin
            fstat = pdie_pkg::ST_OK;
            phase = pdie_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    if (eor) begin
      case (phase)
        pdie_pkg::PH_SEARCH: st = pdie_pkg::ST_NOPREFIX;
        pdie_pkg::PH_SKIPWS: st = pdie_pkg::ST_NODIGIT;
        pdie_pkg::PH_SIGNED: st = pdie_pkg::ST_SIGNONLY;
        pdie_pkg::PH_DIGITS: st = pdie_pkg::ST_OK;
        default:             st = fstat;
      endcase
      r = '0;
      r.parse_status = st;
      if (st == pdie_pkg::ST_OK) begin
        r.parsed_value = neg ? (32'd0 - mag) : mag;
        r.value_saturated = ovf;
      end
      expected_parses.push_back(r);
      clear_parse();
    end
  endtask

  // Input side: record transfers and advance the model
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      absorb_char(s_axis_tdata, s_axis_tlast);
      void'(pending_chars.pop_front());
    end
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
  end

  // Input side: hold an offered char until its transfer, else idle or offer the next
  always @(negedge clk) begin
    if (!s_axis_tvalid || in_taken) begin
      if (src_gap == 0 && !calm && $urandom_range(0, 11) == 0)
        src_gap = $urandom_range(1, 8);
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0 && !rst) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_chars[0].chr;
        s_axis_tlast  <= pending_chars[0].eor;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stall bursts
  always @(negedge clk) begin
    if (dst_gap == 0 && !calm && $urandom_range(0, 9) == 0)
      dst_gap = $urandom_range(1, 8);
    if (dst_gap > 0) begin
      dst_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output side: compare each result transfer with the oldest expected parse
  always @(posedge clk) begin : check_results
    pdie_pkg::result_t got;
    pdie_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = pdie_pkg::result_t'(m_axis_tdata[pdie_pkg::OUT_RAW_W-1:0]);
      if (expected_parses.size() == 0) begin
        $error("unexpected result transfer: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_parses.pop_front();
        if (got.parse_status !== want.parse_status) begin
          $error("parse_status expected %0d got %0d", want.parse_status, got.parse_status);
          mismatches++;
        end
        if (got.parsed_value !== want.parsed_value) begin
          $error("parsed_value expected %0d got %0d",
                 $signed(want.parsed_value), $signed(got.parsed_value));
          mismatches++;
        end
        if (got.value_saturated !== want.value_saturated) begin
          $error("value_saturated expected %0d got %0d",
                 want.value_saturated, got.value_saturated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pdie_pkg::REG_PREFIX_BYTES) pfx_chars = val;
    else pfx_len = val[3:0];
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || expected_parses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_chr(input logic [7:0] b);
    resp_char_t c;
    c.chr = b;
    c.eor = 1'b0;
    draft.push_back(c);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) add_chr(8'($urandom_range(0, 255)));
  endtask

  task automatic add_prefix();
    int unsigned elen;
    elen = (pfx_len > pdie_pkg::PREFIX_MAX) ? pdie_pkg::PREFIX_MAX : pfx_len;
    for (int i = 0; i < elen; i++) add_chr(pfx_chars[8*i +: 8]);
  endtask

  task automatic add_blanks(input int n);
    for (int i = 0; i < n; i++)
      add_chr($urandom_range(0, 1) ? pdie_pkg::CH_SPACE : pdie_pkg::CH_TAB);
  endtask

  task automatic add_decimal(input logic [63:0] v);
    logic [7:0] digs [$];
    do begin
      digs.push_front(8'(pdie_pkg::CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) add_chr(digs[i]);
  endtask

  // Close the draft as one response: mark its last char and queue it for sending
  task automatic commit();
    if (draft.size() == 0) add_noise(1);
    draft[draft.size()-1].eor = 1'b1;
    foreach (draft[i]) pending_chars.push_back(draft[i]);
    phase_chars += draft.size();
    draft.delete();
  endtask

  task automatic add_well_formed(input int sign_kind, input logic [63:0] v);
    add_prefix();
    add_blanks($urandom_range(0, 3));
    if (sign_kind == 1) add_chr(pdie_pkg::CH_MINUS);
    else if (sign_kind == 2) add_chr(pdie_pkg::CH_PLUS);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) add_chr(pdie_pkg::CH_ZERO);
    add_decimal(v);
    if ($urandom_range(0, 1)) add_noise($urandom_range(1, 3));
    commit();
  endtask

  task automatic random_response();
    int          kind;
    logic [63:0] v;
    kind = $urandom_range(0, 9);
    if (pfx_len != 0 && kind != 7) add_noise($urandom_range(0, 3));
    if (kind <= 6) begin
      case ($urandom_range(0, 5))
        0:       v = $urandom_range(0, 999);
        1, 5:    v = 64'd2147483646 + $urandom_range(0, 3);
        2:       v = $urandom;
        3:       v = {$urandom, $urandom};
        default: v = $urandom_range(0, 9);
      endcase
      add_well_formed($urandom_range(0, 2), v);
    end else if (kind == 7) begin
      add_noise($urandom_range(1, 6));
      commit();
    end else if (kind == 8) begin
      add_prefix();
      add_blanks($urandom_range(0, 2));
      if ($urandom_range(0, 1))
        add_chr($urandom_range(0, 1) ? pdie_pkg::CH_MINUS : pdie_pkg::CH_PLUS);
      if ($urandom_range(0, 1)) begin
        add_chr(8'($urandom_range(65, 90)));
        add_noise($urandom_range(0, 2));
      end
      commit();
    end else begin
      add_prefix();
      add_blanks($urandom_range(0, 2));
      add_chr($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(65, 122)));
      add_noise($urandom_range(0, 3));
      commit();
    end
  endtask

  initial begin
    logic [63:0] chars;
    clear_parse();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty prefix from reset
    add_chr(8'hFF);
    commit();
    add_chr(pdie_pkg::CH_MINUS);
    commit();
    add_chr(pdie_pkg::CH_PLUS);
    add_chr("a");
    commit();
    add_chr(pdie_pkg::CH_SPACE);
    add_chr(pdie_pkg::CH_TAB);
    add_chr("9");
    add_chr(8'h00);
    commit();
    add_chr(pdie_pkg::CH_ZERO);
    commit();
    drain();

    // Oversized length clamps to eight chars; match lands on the last char
    write_reg(pdie_pkg::REG_PREFIX_BYTES, '1);
    write_reg(pdie_pkg::REG_PREFIX_LENGTH, 64'd15);
    repeat (8) add_chr(8'hFF);
    commit();
    add_chr("1");
    commit();
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 1) begin
        chars = '0;
      end else if ($urandom_range(0, 1)) begin
        for (int i = 0; i < 8; i++) chars[8*i +: 8] = 8'($urandom_range(33, 126));
      end else begin
        chars = {$urandom, $urandom};
      end
      write_reg(pdie_pkg::REG_PREFIX_BYTES, chars);
      case (p)
        0:       write_reg(pdie_pkg::REG_PREFIX_LENGTH, 64'd0);
        1:       write_reg(pdie_pkg::REG_PREFIX_LENGTH, 64'd8);
        2:       write_reg(pdie_pkg::REG_PREFIX_LENGTH, 64'd15);
        default: write_reg(pdie_pkg::REG_PREFIX_LENGTH, 64'($urandom_range(1, 8)));
      endcase
      calm = (p >= PHASE_COUNT - 2);
      phase_chars = 0;
      if (p == 0) begin
        add_well_formed(1, 64'd2147483648);
        add_well_formed(0, 64'd2147483648);
      end
      while (phase_chars < PHASE_CHARS) random_response();
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
